// ----- hw/rtl/collation_sort_key_weight_emitter_top_assert.svh -----
// Assertion macros shared by the front end and queue modules of the sort key weight emitter.
`ifndef COLLATION_SORT_KEY_WEIGHT_EMITTER_TOP_ASSERT_SVH
`define COLLATION_SORT_KEY_WEIGHT_EMITTER_TOP_ASSERT_SVH

// Check cons in the same cycle as ante.
`define CSKW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cskw assertion failed");

// Check cons in the cycle after ante.
`define CSKW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cskw assertion failed");

`endif

// ----- hw/rtl/cskw_pkg.sv -----
// Types and constants of the sort key weight emitter.
`timescale 1ns / 1ps

package cskw_pkg;

	localparam int WEIGHT_W = 16;
	localparam int LEVEL_CNT_W = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [WEIGHT_W-1:0] QUAT_MAX = 16'hFFFF;

	localparam logic [CFG_IDX_W-1:0] REG_SHIFTED_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VARIABLE_LOW = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VARIABLE_HIGH = 2'd3;

	typedef struct packed {
		logic shifted_mode;
		logic [LEVEL_CNT_W-1:0] level_count;
		logic [WEIGHT_W-1:0] variable_low;
		logic [WEIGHT_W-1:0] variable_high;
	} cfg_t;

	typedef struct packed {
		logic [WEIGHT_W-1:0] weight;
		logic end_of_key;
	} res_t;

endpackage

// ----- hw/rtl/collation_sort_key_weight_emitter_top.sv -----
// Top level of the collation sort key weight emitter.
`timescale 1ns / 1ps

// Builds a sort key from a stream of collation elements that the decoder replays once per
// level, each replay closed by an end-of-pass word. One word is taken per cycle while in_stall
// is low; the front end classifies it and updates level and variable state in that same cycle,
// and any result word passes through the queue into the output register. Up to QUEUE_DEPTH
// results wait in the queue behind the output register before in_stall rises. Write the
// configuration registers only while the block is idle.
module collation_sort_key_weight_emitter_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [15:0] primary_weight,
	input logic [15:0] secondary_weight,
	input logic [15:0] tertiary_weight,
	input logic end_of_pass,
	output logic out_valid,
	input logic out_stall,
	output logic [15:0] weight,
	output logic end_of_key
);
	import cskw_pkg::*;

	cfg_t cfg_q;
	logic acc;
	logic push;
	res_t push_data;
	logic q_full;
	logic q_empty;
	logic pop;
	res_t q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shifted_mode <= 1'b0;
			cfg_q.level_count <= 3'd3;
			cfg_q.variable_low <= 16'd1;
			cfg_q.variable_high <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SHIFTED_MODE: cfg_q.shifted_mode <= cfg_data[0];
				REG_LEVEL_COUNT: cfg_q.level_count <= cfg_data[LEVEL_CNT_W-1:0];
				REG_VARIABLE_LOW: cfg_q.variable_low <= cfg_data;
				REG_VARIABLE_HIGH: cfg_q.variable_high <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = q_full;
	assign acc = in_valid && !q_full;

	cskw_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.acc(acc),
		.primary_weight(primary_weight),
		.secondary_weight(secondary_weight),
		.tertiary_weight(tertiary_weight),
		.end_of_pass(end_of_pass),
		.push(push),
		.push_data(push_data)
	);

	cskw_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(q_full),
		.pop(pop),
		.pop_data(q_data),
		.empty(q_empty)
	);

	cskw_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.q_data(q_data),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.weight(weight),
		.end_of_key(end_of_key)
	);

endmodule

// ----- hw/rtl/cskw_front.sv -----
// Front end: classify each element, track level and variable state, form the result word.
`timescale 1ns / 1ps
`include "collation_sort_key_weight_emitter_top_assert.svh"

module cskw_front (
	input logic clk,
	input logic arst_n,
	input cskw_pkg::cfg_t cfg,
	input logic acc,
	input logic [15:0] primary_weight,
	input logic [15:0] secondary_weight,
	input logic [15:0] tertiary_weight,
	input logic end_of_pass,
	output logic push,
	output cskw_pkg::res_t push_data
);
	import cskw_pkg::*;

	logic [1:0] lvl_q;
	logic prev_var_q;
	logic [2:0] n_lvl;
	logic [2:0] next_lvl;
	logic last;
	logic past_last;
	logic [15:0] w0, w1, w2, w3;
	logic var_now;
	logic in_range;
	logic [15:0] sel;

	always_comb begin
		if (cfg.level_count == 3'd0) begin
			n_lvl = 3'd1;
		end else if (cfg.level_count > 3'd4) begin
			n_lvl = 3'd4;
		end else begin
			n_lvl = cfg.level_count;
		end
	end

	assign next_lvl = {1'b0, lvl_q} + 3'd1;
	assign last = next_lvl >= n_lvl;
	assign past_last = {1'b0, lvl_q} >= n_lvl;

	assign in_range = (primary_weight != 16'd0) && (primary_weight >= cfg.variable_low)
		&& (primary_weight <= cfg.variable_high);

	always_comb begin
		w0 = primary_weight;
		w1 = secondary_weight;
		w2 = tertiary_weight;
		w3 = 16'd0;
		var_now = in_range;
		if (cfg.shifted_mode) begin
			if (primary_weight == 16'd0 && secondary_weight == 16'd0
				&& tertiary_weight == 16'd0) begin
				w3 = 16'd0;
			end else if (primary_weight == 16'd0 && tertiary_weight != 16'd0
				&& prev_var_q) begin
				w0 = 16'd0;
				w1 = 16'd0;
				w2 = 16'd0;
				var_now = 1'b1;
			end else if (in_range) begin
				w0 = 16'd0;
				w1 = 16'd0;
				w2 = 16'd0;
				w3 = primary_weight;
			end else if (primary_weight != 16'd0 || tertiary_weight != 16'd0) begin
				w3 = QUAT_MAX;
			end
		end
	end

	always_comb begin
		case (lvl_q)
			2'd0: sel = w0;
			2'd1: sel = w1;
			2'd2: sel = w2;
			default: sel = w3;
		endcase
	end

	always_comb begin
		push = 1'b0;
		push_data.weight = 16'd0;
		push_data.end_of_key = 1'b0;
		if (acc) begin
			if (end_of_pass) begin
				push = 1'b1;
				push_data.end_of_key = last;
			end else if (!past_last && sel != 16'd0) begin
				push = 1'b1;
				push_data.weight = sel;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= 2'd0;
			prev_var_q <= 1'b0;
		end else if (acc) begin
			if (end_of_pass) begin
				prev_var_q <= 1'b0;
				lvl_q <= last ? 2'd0 : next_lvl[1:0];
			end else if (!past_last && cfg.shifted_mode) begin
				prev_var_q <= var_now;
			end
		end
	end

	`CSKW_ASSERT_NEXT(a_key_end_clears, clk, arst_n, acc && end_of_pass && last, lvl_q == 2'd0 && !prev_var_q)
	`CSKW_ASSERT_NEXT(a_past_last_holds, clk, arst_n, acc && !end_of_pass && past_last, lvl_q == $past(lvl_q) && prev_var_q == $past(prev_var_q))
	`CSKW_ASSERT_NOW(a_key_end_on_pass, clk, arst_n, push && push_data.end_of_key, end_of_pass && push_data.weight == 16'd0)

endmodule

// ----- hw/rtl/cskw_queue.sv -----
// Result queue between the front end and the output stage.
`timescale 1ns / 1ps
`include "collation_sort_key_weight_emitter_top_assert.svh"

module cskw_queue #(
	parameter int DEPTH = 2
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cskw_pkg::res_t push_data,
	output logic full,
	input logic pop,
	output cskw_pkg::res_t pop_data,
	output logic empty
);
	import cskw_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	res_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = count_q == CNT_FULL;
	assign empty = count_q == '0;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`CSKW_ASSERT_NOW(a_no_push_full, clk, arst_n, push, !full)
	`CSKW_ASSERT_NOW(a_no_pop_empty, clk, arst_n, pop, !empty)
	`CSKW_ASSERT_NEXT(a_count_up, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1)

endmodule

// ----- hw/rtl/cskw_back.sv -----
// Output stage: register each result word and hold it while stalled.
`timescale 1ns / 1ps

module cskw_back (
	input logic clk,
	input logic arst_n,
	input logic q_empty,
	input cskw_pkg::res_t q_data,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output logic [15:0] weight,
	output logic end_of_key
);
	import cskw_pkg::*;

	logic valid_q;
	res_t data_q;

	assign pop = !q_empty && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign weight = data_q.weight;
	assign end_of_key = data_q.end_of_key;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			data_q <= q_data;
		end
	end

endmodule

// ----- test/collation_sort_key_weight_emitter_top_tb.sv -----
// Self-checking testbench of the collation sort key weight emitter.
`timescale 1ns / 1ps

module collation_sort_key_weight_emitter_top_tb;
	import cskw_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 48;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASES = 12;
	localparam int WORDS_PER_PHASE = 40;

	class key_weight_tracker;
		logic shifted;
		logic [LEVEL_CNT_W-1:0] level_reg;
		logic [WEIGHT_W-1:0] var_lo;
		logic [WEIGHT_W-1:0] var_hi;
		logic [LEVEL_CNT_W-1:0] level;
		bit after_variable;
		res_t expected_weights[$];
		int errors;
		int results_checked;
		int keys_done;

		function new();
			shifted = 1'b0;
			level_reg = 3'd3;
			var_lo = 16'd1;
			var_hi = 16'd0;
			level = '0;
			after_variable = 1'b0;
			errors = 0;
			results_checked = 0;
			keys_done = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [WEIGHT_W-1:0] val);
			case (idx)
				REG_SHIFTED_MODE: shifted = val[0];
				REG_LEVEL_COUNT: level_reg = val[LEVEL_CNT_W-1:0];
				REG_VARIABLE_LOW: var_lo = val;
				REG_VARIABLE_HIGH: var_hi = val;
				default: ;
			endcase
		endfunction

		function int active_levels();
			if (level_reg < 1) return 1;
			if (level_reg > 4) return 4;
			return int'(level_reg);
		endfunction

		function void take_word(logic [WEIGHT_W-1:0] p, logic [WEIGHT_W-1:0] s,
				logic [WEIGHT_W-1:0] t, logic eop);
			logic [WEIGHT_W-1:0] w [4];
			bit is_var;
			res_t r;
			int n;
			n = active_levels();
			if (eop) begin
				after_variable = 1'b0;
				r.weight = '0;
				if (int'(level) + 1 < n) begin
					level = level + 1'b1;
					r.end_of_key = 1'b0;
				end else begin
					level = '0;
					r.end_of_key = 1'b1;
				end
				expected_weights.push_back(r);
				return;
			end
			if (int'(level) >= n) return;
			w[0] = p;
			w[1] = s;
			w[2] = t;
			w[3] = '0;
			if (shifted) begin
				is_var = (p != 0) && (p >= var_lo) && (p <= var_hi);
				if (p == 0 && s == 0 && t == 0) begin
					w[3] = '0;
				end else if (p == 0 && t != 0 && after_variable) begin
					w[0] = '0;
					w[1] = '0;
					w[2] = '0;
					is_var = 1'b1;
				end else if (p != 0 && is_var) begin
					w[0] = '0;
					w[1] = '0;
					w[2] = '0;
					w[3] = p;
				end else if (p != 0 || t != 0) begin
					w[3] = QUAT_MAX;
				end
				after_variable = is_var;
			end
			if (w[level[1:0]] == 0) return;
			r.weight = w[level[1:0]];
			r.end_of_key = 1'b0;
			expected_weights.push_back(r);
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_weight(logic [WEIGHT_W-1:0] got_weight, logic got_end);
			res_t e;
			if (expected_weights.size() == 0) begin
				report($sformatf("unexpected word weight=%h end_of_key=%b", got_weight, got_end));
			end else begin
				e = expected_weights.pop_front();
				results_checked++;
				if (got_weight !== e.weight)
					report($sformatf("weight %h, expected %h", got_weight, e.weight));
				if (got_end !== e.end_of_key)
					report($sformatf("end_of_key %b, expected %b", got_end, e.end_of_key));
				if (e.end_of_key)
					keys_done++;
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [15:0] primary_weight;
	logic [15:0] secondary_weight;
	logic [15:0] tertiary_weight;
	logic end_of_pass;
	logic out_valid;
	logic out_stall;
	logic [15:0] weight;
	logic end_of_key;

	key_weight_tracker tracker = new();
	bit tx_jitter;
	bit rx_jitter;
	bit long_hold_req;
	int words_sent;
	int cycles;
	int in_stall_cycles;
	int hold_count;

	collation_sort_key_weight_emitter_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.primary_weight(primary_weight),
		.secondary_weight(secondary_weight),
		.tertiary_weight(tertiary_weight),
		.end_of_pass(end_of_pass),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.weight(weight),
		.end_of_key(end_of_key)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (arst_n && in_valid && in_stall === 1'b1)
			in_stall_cycles++;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0)
			tracker.check_weight(weight, end_of_key);
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles,
				tracker.expected_weights.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int stall_left;
		stall_left = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_stall = 1'b1;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_count++;
				stall_left = HOLD_CYCLES - 1;
				out_stall = 1'b1;
			end else if (rx_jitter && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 3);
				out_stall = 1'b1;
			end else begin
				out_stall = 1'b0;
			end
		end
	end

	task automatic send_word(input logic [15:0] p, input logic [15:0] s, input logic [15:0] t,
			input logic eop);
		int gap;
		if (tx_jitter && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 4);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		primary_weight = p;
		secondary_weight = s;
		tertiary_weight = t;
		end_of_pass = eop;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		tracker.take_word(p, s, t, eop);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_pass_end();
		send_word(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
	endtask

	task automatic go_idle();
		in_valid = 1'b0;
		while (tracker.expected_weights.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		tracker.set_register(idx, val);
	endtask

	task automatic make_element(output logic [15:0] p, output logic [15:0] s,
			output logic [15:0] t);
		int kind;
		kind = $urandom_range(0, 9);
		s = ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom);
		t = ($urandom_range(0, 3) == 0) ? 16'h0 : 16'($urandom);
		case (kind)
			0, 1, 2: p = 16'($urandom_range(tracker.var_lo, tracker.var_hi));
			3, 4: begin
				p = 16'h0;
				t = 16'($urandom_range(1, 16'hFFFF));
			end
			5, 6: p = 16'($urandom);
			7: begin
				p = 16'h0;
				s = 16'h0;
				t = 16'h0;
			end
			8: begin
				p = 16'h0;
				s = 16'($urandom_range(1, 16'hFFFF));
				t = 16'h0;
			end
			default: begin
				case ($urandom_range(0, 5))
					0: p = 16'hFFFF;
					1: p = 16'h0001;
					2: p = tracker.var_lo;
					3: p = tracker.var_hi;
					4: p = tracker.var_lo - 1'b1;
					default: p = tracker.var_hi + 1'b1;
				endcase
				s = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0;
				t = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0001;
			end
		endcase
	endtask

	task automatic send_string(input int len, input int passes);
		logic [15:0] ep [16];
		logic [15:0] es [16];
		logic [15:0] et [16];
		for (int i = 0; i < len; i++)
			make_element(ep[i], es[i], et[i]);
		for (int k = 0; k < passes; k++) begin
			for (int i = 0; i < len; i++)
				send_word(ep[i], es[i], et[i], 1'b0);
			send_pass_end();
		end
	endtask

	initial begin
		int target;
		int pick;
		logic [15:0] lo;
		logic [15:0] hi;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		primary_weight = '0;
		secondary_weight = '0;
		tertiary_weight = '0;
		end_of_pass = 1'b0;
		tx_jitter = 1'b1;
		rx_jitter = 1'b1;
		long_hold_req = 1'b0;
		words_sent = 0;
		cycles = 0;
		in_stall_cycles = 0;
		hold_count = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// non-ignorable weighting, three levels
		send_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
		send_word(16'h0000, 16'h0000, 16'h0000, 1'b0);
		send_pass_end();
		send_word(16'h0001, 16'h0001, 16'h0001, 1'b0);
		send_pass_end();
		send_pass_end();

		// shifted weighting, four levels
		go_idle();
		write_reg(REG_SHIFTED_MODE, 16'h0001);
		write_reg(REG_LEVEL_COUNT, 16'h0004);
		write_reg(REG_VARIABLE_LOW, 16'h0200);
		write_reg(REG_VARIABLE_HIGH, 16'h0FFF);
		send_word(16'h0300, 16'h0020, 16'h0002, 1'b0);
		send_word(16'h0000, 16'h0020, 16'h0002, 1'b0);
		send_word(16'h2000, 16'h0020, 16'h0002, 1'b0);
		send_pass_end();
		send_pass_end();
		send_pass_end();
		send_word(16'h0300, 16'h0020, 16'h0002, 1'b0);
		send_word(16'h0000, 16'h0000, 16'h0007, 1'b0);
		send_word(16'h0FFF, 16'h0005, 16'h0005, 1'b0);
		send_word(16'h0000, 16'h0000, 16'h0007, 1'b0);
		send_word(16'h2000, 16'h0020, 16'h0002, 1'b0);
		send_word(16'h0000, 16'h0020, 16'h0000, 1'b0);
		send_word(16'h0000, 16'h0000, 16'h0000, 1'b0);

		// lower the level count mid-key: elements drop until the pass ends
		go_idle();
		write_reg(REG_LEVEL_COUNT, 16'h0002);
		send_word(16'h2000, 16'h0001, 16'h0001, 1'b0);
		send_pass_end();

		// full variable range, level count above four
		go_idle();
		write_reg(REG_VARIABLE_LOW, 16'h0000);
		write_reg(REG_VARIABLE_HIGH, 16'hFFFF);
		write_reg(REG_LEVEL_COUNT, 16'h0007);
		send_pass_end();
		send_pass_end();
		send_pass_end();
		send_word(16'h0000, 16'h0003, 16'h0009, 1'b0);
		send_word(16'hFFFF, 16'h0000, 16'h0000, 1'b0);
		send_word(16'h0001, 16'h0001, 16'h0001, 1'b0);
		send_pass_end();

		for (int ph = 0; ph < PHASES; ph++) begin
			go_idle();
			case (ph % 4)
				0: begin
					lo = 16'($urandom_range(1, 16'h3FFF));
					hi = lo + 16'($urandom_range(0, 16'h3FFF));
				end
				1: begin
					lo = 16'h0000;
					hi = 16'hFFFF;
				end
				2: begin
					lo = 16'($urandom_range(16'h8000, 16'hFFFF));
					hi = 16'($urandom_range(0, lo - 1));
				end
				default: begin
					lo = 16'($urandom_range(1, 16'hFFFF));
					hi = lo;
				end
			endcase
			write_reg(REG_VARIABLE_HIGH, hi);
			write_reg(REG_SHIFTED_MODE, {15'($urandom), 1'(ph % 3 != 0)});
			write_reg(REG_VARIABLE_LOW, lo);
			write_reg(REG_LEVEL_COUNT, {13'($urandom), 3'(ph % 8)});
			tx_jitter = (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
			rx_jitter = (ph < PHASES - 1) && ($urandom_range(0, 3) != 0);
			if (ph == 2 || ph == 7)
				long_hold_req = 1'b1;
			target = words_sent + WORDS_PER_PHASE;
			while (words_sent < target) begin
				pick = $urandom_range(0, 9);
				if (pick < 7)
					send_string($urandom_range(1, 6), tracker.active_levels());
				else if (pick == 7)
					send_string($urandom_range(1, 6), $urandom_range(1, 5));
				else if (pick == 8)
					send_string($urandom_range(7, 14), tracker.active_levels());
				else
					send_word(16'($urandom), 16'($urandom), 16'($urandom),
						1'($urandom_range(0, 1)));
			end
		end

		go_idle();
		$display("covered %0d words in, %0d results checked, %0d sort keys completed",
			words_sent, tracker.results_checked, tracker.keys_done);
		$display("both weighting modes, level counts 0 to 7, %0d long output holds, %0d %s",
			hold_count, in_stall_cycles, "input stall cycles");
		if (tracker.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
